[hdl/bitmap_page_allocator_top_macros.svh]
// assertion macros for the bitmap page allocator
// used by the top level, no other dependencies
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BPA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BPA_ASSERT(label, clk, rst_n, prop, msg)
`define BPA_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

[hdl/bpa_pkg.sv]
// package for the bitmap page allocator
// operation codes, config indices, count limit and fixed field widths, no dependencies
package bpa_pkg;
    localparam int unsigned FUNC_W  = 3;
    localparam int unsigned ADDR_W  = 24;
    localparam int unsigned SIZE_W  = 25;
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned MBYTE_W = 10;
    localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;

    localparam logic [FUNC_W-1:0] FN_ALLOC     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_FREE      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MARK      = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MARK_TALLY = 3'd3;
    localparam logic [FUNC_W-1:0] FN_INIT      = 3'd4;

    localparam logic CFG_MAP_BYTES  = 1'b0;
    localparam logic CFG_INIT_COUNT = 1'b1;
endpackage

[hdl/bpa_ram.sv]
// generic single port ram with registered read
// no dependencies
module bpa_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

[hdl/bitmap_page_allocator_top.sv]
// bitmap page allocator top level: sequencer over one page map ram
// depends on bpa_pkg, bpa_ram and bitmap_page_allocator_top_macros.svh
//
// One operation at a time. Every page access reads or writes one map bit
// through the single ram port: a read passes through address, ram access
// and data states, a write is a single request. Allocate checks each
// candidate start, then reads each page examined and marks each page
// allocated; free and mark read and then write each page. Init and the
// clearing pass after reset write every map entry once, setting it to used,
// during which busy is high. o_done is high for one cycle and cannot be held.
`include "bitmap_page_allocator_top_macros.svh"
module bitmap_page_allocator_top #(
    parameter int unsigned MAX_PAGES  = 4096,
    parameter int unsigned PAGE_BYTES = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [bpa_pkg::CNT_W-1:0]     i_cfg_data,
    input  logic [bpa_pkg::FUNC_W-1:0]    i_func,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_phys_address,
    input  logic [bpa_pkg::SIZE_W-1:0]    i_size_bytes,
    input  logic                          i_mark_used,
    output logic                          o_done,
    output logic [bpa_pkg::ADDR_W-1:0]    o_result_value,
    output logic                          o_failed,
    output logic [bpa_pkg::CNT_W-1:0]     o_used_count
);
    localparam int unsigned PW  = $clog2(MAX_PAGES);
    localparam int unsigned TW  = PW + 1;
    localparam int unsigned SH  = $clog2(PAGE_BYTES);
    localparam int unsigned NW  = bpa_pkg::SIZE_W - SH + 1;
    localparam int unsigned WW  = (NW > TW ? NW : TW) + 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ACHK, S_ARD, S_AGAP, S_AWAIT, S_AMARK,
        S_MCHK, S_MRD, S_MWAIT, S_MEND, S_DONE
    } t_state;

    t_state r_state;
    logic [bpa_pkg::MBYTE_W-1:0] r_map_bytes;
    logic [bpa_pkg::CNT_W-1:0]   r_init_cnt, r_count;
    logic [PW-1:0]  r_hint;
    logic [WW-1:0]  r_n, r_i, r_p, r_end, r_total;
    logic           r_pass2, r_target, r_tally, r_fail, r_free;
    logic [bpa_pkg::FUNC_W-1:0] r_func;
    logic [bpa_pkg::ADDR_W-1:0] r_res;
    logic           r_we, r_wd;
    logic [PW-1:0]  r_ra;
    logic           w_rd;

    logic [WW-1:0]  w_tot_cfg, w_n_in, w_pg_in, w_total_cnt;
    logic [WW-1:0]  w_cand_end;

    assign w_tot_cfg = ({{(WW-bpa_pkg::MBYTE_W){1'b0}}, r_map_bytes} << 3) > WW'(MAX_PAGES)
                     ? WW'(MAX_PAGES)
                     : ({{(WW-bpa_pkg::MBYTE_W){1'b0}}, r_map_bytes} << 3);
    assign w_n_in  = WW'(({1'b0, i_size_bytes} + (bpa_pkg::SIZE_W+1)'(PAGE_BYTES - 1)) >> SH);
    assign w_pg_in = WW'(i_phys_address >> SH);
    assign w_cand_end = r_p + r_n;
    assign w_total_cnt = WW'(r_count) + r_n;

    bpa_ram #(.WIDTH(1), .DEPTH(MAX_PAGES)) u_map (
        .i_clk(i_clk), .i_we(r_we), .i_addr(r_ra), .i_wdata(r_wd), .o_rdata(w_rd)
    );

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_map_bytes <= 10'd512;
            r_init_cnt  <= '0;
            r_count     <= '0;
            r_hint      <= '0;
            r_i         <= '0;
            r_we        <= 1'b0;
            r_free      <= 1'b0;
            o_done      <= 1'b0;
        end else begin
            o_done <= 1'b0;
            r_we   <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_index == bpa_pkg::CFG_MAP_BYTES) begin
                    r_map_bytes <= i_cfg_data[bpa_pkg::MBYTE_W-1:0];
                end else begin
                    r_init_cnt <= i_cfg_data;
                end
            end
            case (r_state)
                S_CLEAR: begin
                    r_we <= 1'b1;
                    r_wd <= 1'b1;
                    r_ra <= r_i[PW-1:0];
                    r_i  <= r_i + 1'b1;
                    if (r_i == WW'(MAX_PAGES - 1)) begin
                        r_free  <= 1'b0;
                        r_state <= r_free ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_func   <= i_func;
                        r_total  <= w_tot_cfg;
                        r_n      <= w_n_in;
                        r_fail   <= 1'b0;
                        r_res    <= '0;
                        r_pass2  <= 1'b0;
                        r_target <= (i_func == bpa_pkg::FN_FREE) ? 1'b0 : i_mark_used;
                        r_tally  <= (i_func != bpa_pkg::FN_MARK);
                        r_p      <= WW'(r_hint);
                        r_end    <= w_tot_cfg;
                        case (i_func)
                            bpa_pkg::FN_ALLOC: r_state <= S_ACHK;
                            bpa_pkg::FN_FREE, bpa_pkg::FN_MARK, bpa_pkg::FN_MARK_TALLY: begin
                                r_p <= w_pg_in;
                                r_i <= w_pg_in;
                                if (i_phys_address[SH-1:0] != '0 || w_pg_in >= w_tot_cfg) begin
                                    r_fail  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_end   <= w_pg_in + w_n_in;
                                    r_state <= S_MCHK;
                                end
                            end
                            bpa_pkg::FN_INIT: begin
                                r_count <= r_init_cnt;
                                r_hint  <= '0;
                                r_i     <= '0;
                                r_free  <= 1'b1;
                                r_state <= S_CLEAR;
                            end
                            default: begin
                                r_fail  <= 1'b1;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                // candidate start r_p within [.., r_end)
                S_ACHK: begin
                    if (r_p >= r_end) begin
                        if (!r_pass2) begin
                            r_pass2 <= 1'b1;
                            r_p     <= WW'(1);
                            r_end   <= WW'(r_hint);
                        end else begin
                            r_fail  <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end else if (w_cand_end > r_total) begin
                        if (r_n != '0) begin
                            if (!r_pass2) begin
                                r_pass2 <= 1'b1;
                                r_p     <= WW'(1);
                                r_end   <= WW'(r_hint);
                            end else begin
                                r_fail  <= 1'b1;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_p <= r_p + 1'b1;
                        end
                    end else begin
                        r_i     <= r_p;
                        r_state <= S_ARD;
                    end
                end
                S_ARD: begin
                    if (r_i == w_cand_end) begin
                        r_i     <= r_p;
                        r_state <= S_AMARK;
                    end else begin
                        r_ra    <= r_i[PW-1:0];
                        r_state <= S_AGAP;
                    end
                end
                S_AGAP: begin
                    r_state <= S_AWAIT;
                end
                S_AWAIT: begin
                    if (w_rd) begin
                        r_p     <= w_cand_end;
                        r_state <= S_ACHK;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_AMARK: begin
                    if (r_i == w_cand_end) begin
                        r_count <= (w_total_cnt > WW'(bpa_pkg::COUNT_MAX))
                                 ? bpa_pkg::COUNT_MAX : w_total_cnt[bpa_pkg::CNT_W-1:0];
                        r_res   <= bpa_pkg::ADDR_W'({r_p[PW-1:0], {SH{1'b0}}});
                        r_state <= S_DONE;
                    end else begin
                        r_we <= 1'b1;
                        r_wd <= 1'b1;
                        r_ra <= r_i[PW-1:0];
                        r_i  <= r_i + 1'b1;
                    end
                end
                S_MCHK: begin
                    if (r_i == r_end) begin
                        r_state <= S_MEND;
                    end else if (r_i >= r_total) begin
                        r_fail  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_ra    <= r_i[PW-1:0];
                        r_state <= S_MRD;
                    end
                end
                S_MRD: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_rd == r_target) begin
                        r_fail  <= 1'b1;
                        r_state <= S_DONE;
                    end else begin
                        r_we    <= 1'b1;
                        r_wd    <= r_target;
                        r_i     <= r_i + 1'b1;
                        r_state <= S_MCHK;
                    end
                end
                S_MEND: begin
                    r_state <= S_DONE;
                    if (r_tally && r_target) begin
                        r_count <= (w_total_cnt > WW'(bpa_pkg::COUNT_MAX))
                                 ? bpa_pkg::COUNT_MAX : w_total_cnt[bpa_pkg::CNT_W-1:0];
                    end else if (r_tally && r_n > WW'(r_count)) begin
                        r_fail <= 1'b1;
                    end else if (r_tally) begin
                        r_count <= r_count - r_n[bpa_pkg::CNT_W-1:0];
                    end
                    if (!(r_tally && !r_target && r_n > WW'(r_count))) begin
                        if (r_func == bpa_pkg::FN_FREE) begin
                            r_hint <= r_p[PW-1:0];
                        end else begin
                            r_res <= bpa_pkg::ADDR_W'(r_p);
                        end
                    end
                end
                S_DONE: begin
                    o_done         <= 1'b1;
                    o_result_value <= r_res;
                    o_failed       <= r_fail;
                    o_used_count   <= r_count;
                    r_state        <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `BPA_ASSERT(a_done_from_done, i_clk, i_rst_n,
        o_done |-> $past(r_state) == S_DONE, "done without finishing state")
    `BPA_ASSERT(a_no_write_idle, i_clk, i_rst_n,
        (r_state == S_IDLE && !$past(r_state == S_AMARK || r_state == S_MWAIT
            || r_state == S_CLEAR)) |-> !r_we, "map write while idle")
    `BPA_ASSERT(a_start_leaves_idle, i_clk, i_rst_n,
        (r_state == S_IDLE && start) |=> r_state != S_IDLE, "start ignored")
    `BPA_ASSERT_NEVER(a_done_not_busy, i_clk, i_rst_n, o_done && busy, "done while busy")
endmodule
